@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the descriptor matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define RGDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RGDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/rgdm_pkg.sv @@
// Shared types, codes and constants of the radius-gated descriptor matcher.
package rgdm_pkg;

  localparam int unsigned MAX_REFS_DEF  = 512;
  localparam int unsigned NUM_LANES_DEF = 4;
  localparam int unsigned DESC_BYTES    = 32;
  localparam int unsigned DESC_BITS     = DESC_BYTES * 8;
  localparam int unsigned GROUP_BYTES   = 8;
  localparam int unsigned NUM_GROUPS    = DESC_BYTES / GROUP_BYTES;
  localparam int unsigned PSUM_W        = 11;
  localparam int unsigned SAD_W         = 13;
  localparam int unsigned R2_W          = 32;
  localparam int unsigned LANE_LAT      = 3;
  localparam logic [15:0] RADIUS_RST    = 16'd320;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [63:0] desc_word_0;
    logic [63:0] desc_word_1;
    logic [63:0] desc_word_2;
    logic [63:0] desc_word_3;
  } in_req_t;

  typedef struct packed {
    logic [15:0] query_index;
    logic        matched;
    logic [8:0]  ref_index;
    logic [12:0] distance_sum;
    logic        overflow;
  } result_t;

  // Position and descriptor of one keypoint, byte 0 in the low bits.
  typedef struct packed {
    logic [15:0]          pos_x;
    logic [15:0]          pos_y;
    logic [DESC_BITS-1:0] desc;
  } point_t;

  typedef struct packed {
    logic             hit;
    logic [SAD_W-1:0] sad;
  } lane_res_t;

  typedef struct packed {
    logic go;
    logic first;
    logic last;
  } scan_tag_t;

endpackage

@@ design/radius_gated_descriptor_match.sv @@
// Radius-gated brute-force descriptor matcher: reference store, lanes and control.
//
// Operations are taken when start is high and busy is low. Clear and add leave
// busy low. A query raises busy and scans the stored entries one row of
// NUM_LANES entries per cycle, ceil(count / NUM_LANES) rows (at least one),
// then drains a five-stage lane and merge pipeline before the result strobe,
// and the next operation can be taken in the cycle after the strobe. With the
// defaults a full set of 512 entries gives 128 rows. The result is shown for
// exactly one cycle under result_valid_o and cannot be stalled. Entries are
// striped across the lanes' memory banks, one read port per bank, which sets
// the scan rate. No clearing pass is needed after reset.
module radius_gated_descriptor_match #(
  parameter int unsigned MAX_REFS  = rgdm_pkg::MAX_REFS_DEF,
  parameter int unsigned NUM_LANES = rgdm_pkg::NUM_LANES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  rgdm_pkg::in_req_t req_i,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output logic              result_valid_o,
  output rgdm_pkg::result_t result_o
);
  import rgdm_pkg::*;

  // NUM_LANES is a power of two, at least two.
  localparam int unsigned LANE_W = $clog2(NUM_LANES);
  localparam int unsigned ROWS   = (MAX_REFS + NUM_LANES - 1) / NUM_LANES;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned ENT_W  = ROW_W + LANE_W;
  localparam int unsigned CMP_W  = ENT_W + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_REFS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]       state_d, state_q;
  logic [ROW_W-1:0] row_d, row_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [15:0]      qcnt_d, qcnt_q;
  logic             ovf_d, ovf_q;
  logic [R2_W-1:0]  r2_q;
  point_t           qry_q;
  point_t           in_point;

  logic             accept;
  logic             add_ok;
  logic [ROW_W-1:0] wr_row;
  logic [LANE_W-1:0] wr_lane;
  logic [CMP_W-1:0] row_base;
  logic             last_row;
  scan_tag_t        tag;
  logic [NUM_LANES-1:0] lane_vld;
  lane_res_t [NUM_LANES-1:0] lane_res;

  logic             done;
  logic             found;
  logic [ENT_W-1:0] best_idx;
  logic [SAD_W-1:0] best_sad;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign add_ok  = cnt_q < CNT_W'(MAX_REFS);
  assign wr_row  = ROW_W'(cnt_q >> LANE_W);
  assign wr_lane = LANE_W'(cnt_q);

  assign in_point.pos_x = req_i.pos_x;
  assign in_point.pos_y = req_i.pos_y;
  assign in_point.desc  = {req_i.desc_word_3, req_i.desc_word_2,
                           req_i.desc_word_1, req_i.desc_word_0};

  assign row_base = CMP_W'({row_q, LANE_W'(0)});
  assign last_row = (row_base + CMP_W'(NUM_LANES)) >= CMP_W'(cnt_q);

  assign tag.go    = (state_q == S_SCAN);
  assign tag.first = (row_q == '0);
  assign tag.last  = last_row;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_vld[l] = tag.go && ((row_base + CMP_W'(l)) < CMP_W'(cnt_q));
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    qcnt_d  = qcnt_q;
    ovf_d   = ovf_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.operation)
            OP_CLEAR: begin
              cnt_d  = '0;
              qcnt_d = '0;
              ovf_d  = 1'b0;
            end
            OP_ADD: begin
              if (add_ok) begin
                cnt_d = cnt_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_QUERY: begin
              row_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
              // drop unused operation code
            end
          endcase
        end
      end
      S_SCAN: begin
        row_d = row_q + ROW_W'(1);
        if (last_row) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (done) begin
          qcnt_d  = qcnt_q + 16'd1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      cnt_q   <= '0;
      qcnt_q  <= '0;
      ovf_q   <= 1'b0;
      r2_q    <= R2_W'(RADIUS_RST) * R2_W'(RADIUS_RST);
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      qcnt_q  <= qcnt_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) begin
        r2_q <= R2_W'(cfg_wdata_i) * R2_W'(cfg_wdata_i);
      end
    end
  end

  // Hold the query keypoint for the whole scan.
  always_ff @(posedge clk_i) begin
    if (accept && req_i.operation == OP_QUERY) begin
      qry_q <= in_point;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rgdm_lane #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (accept && req_i.operation == OP_ADD && add_ok &&
                   wr_lane == LANE_W'(l)),
      .wr_row_i   (wr_row),
      .wr_point_i (in_point),
      .rd_en_i    (lane_vld[l]),
      .rd_row_i   (row_q),
      .qry_i      (qry_q),
      .r2_i       (r2_q),
      .res_o      (lane_res[l])
    );
  end

  rgdm_merge #(
    .NUM_LANES (NUM_LANES),
    .LANE_W    (LANE_W),
    .ROW_W     (ROW_W),
    .ENT_W     (ENT_W)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .row_i   (row_q),
    .lanes_i (lane_res),
    .done_o  (done),
    .found_o (found),
    .idx_o   (best_idx),
    .sad_o   (best_sad)
  );

  assign result_valid_o        = done;
  assign result_o.query_index  = qcnt_q;
  assign result_o.matched      = found;
  assign result_o.ref_index    = found ? 9'(best_idx) : 9'd0;
  assign result_o.distance_sum = found ? best_sad : '0;
  assign result_o.overflow     = ovf_q;

endmodule

@@ design/rgdm_lane.sv @@
// One matching lane: a bank of reference entries, radius gate and byte SAD.
module rgdm_lane #(
  parameter int unsigned ROWS  = 128,
  parameter int unsigned ROW_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [ROW_W-1:0]   wr_row_i,
  input  rgdm_pkg::point_t   wr_point_i,
  input  logic               rd_en_i,
  input  logic [ROW_W-1:0]   rd_row_i,
  input  rgdm_pkg::point_t   qry_i,
  input  logic [31:0]        r2_i,
  output rgdm_pkg::lane_res_t res_o
);
  import rgdm_pkg::*;

  point_t mem [ROWS];
  point_t ent_q;
  logic   vld1_q;

  logic [15:0]       dx, dy;
  logic [PSUM_W-1:0] psum [NUM_GROUPS];
  logic [31:0]       dx2_q, dy2_q;
  logic [PSUM_W-1:0] psum_q [NUM_GROUPS];
  logic              vld2_q;

  logic [32:0]       d2;
  logic [SAD_W-1:0]  sad;
  lane_res_t         res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_point_i;
    end
    ent_q <= mem[rd_row_i];
  end

  always_comb begin
    logic [7:0] a, b;
    dx = (qry_i.pos_x > ent_q.pos_x) ? qry_i.pos_x - ent_q.pos_x : ent_q.pos_x - qry_i.pos_x;
    dy = (qry_i.pos_y > ent_q.pos_y) ? qry_i.pos_y - ent_q.pos_y : ent_q.pos_y - qry_i.pos_y;
    a = '0;
    b = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      psum[g] = '0;
      for (int k = 0; k < GROUP_BYTES; k++) begin
        a = qry_i.desc[(g*GROUP_BYTES + k)*8 +: 8];
        b = ent_q.desc[(g*GROUP_BYTES + k)*8 +: 8];
        psum[g] = psum[g] + PSUM_W'((a > b) ? a - b : b - a);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx2_q <= 32'(dx) * 32'(dx);
    dy2_q <= 32'(dy) * 32'(dy);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      psum_q[g] <= psum[g];
    end
  end

  always_comb begin
    d2  = 33'(dx2_q) + 33'(dy2_q);
    sad = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sad = sad + SAD_W'(psum_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      res_q  <= '0;
    end else begin
      vld1_q    <= rd_en_i;
      vld2_q    <= vld1_q;
      res_q.hit <= vld2_q && (d2 <= 33'(r2_i));
      res_q.sad <= sad;
    end
  end

  assign res_o = res_q;

endmodule

@@ design/rgdm_merge.sv @@
// Lane merge: picks the first lowest SAD of a row, then keeps the running best.
module rgdm_merge #(
  parameter int unsigned NUM_LANES = 4,
  parameter int unsigned LANE_W    = 2,
  parameter int unsigned ROW_W     = 7,
  parameter int unsigned ENT_W     = 9
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rgdm_pkg::scan_tag_t                   tag_i,
  input  logic [ROW_W-1:0]                      row_i,
  input  rgdm_pkg::lane_res_t [NUM_LANES-1:0]   lanes_i,
  output logic                                  done_o,
  output logic                                  found_o,
  output logic [ENT_W-1:0]                      idx_o,
  output logic [rgdm_pkg::SAD_W-1:0]            sad_o
);
  import rgdm_pkg::*;

  scan_tag_t        tag_dl_q [LANE_LAT];
  logic [ROW_W-1:0] row_dl_q [LANE_LAT];

  logic              row_found;
  logic [SAD_W-1:0]  row_sad;
  logic [LANE_W-1:0] row_lane;

  scan_tag_t         c_tag_q;
  logic              c_found_q;
  logic [SAD_W-1:0]  c_sad_q;
  logic [ENT_W-1:0]  c_idx_q;

  logic              best_found_d, best_found_q;
  logic [SAD_W-1:0]  best_sad_d, best_sad_q;
  logic [ENT_W-1:0]  best_idx_d, best_idx_q;
  logic              done_q;

  // Align the row tag with the lane results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        tag_dl_q[i] <= '0;
      end
    end else begin
      tag_dl_q[0] <= tag_i;
      for (int i = 1; i < LANE_LAT; i++) begin
        tag_dl_q[i] <= tag_dl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_dl_q[0] <= row_i;
    for (int i = 1; i < LANE_LAT; i++) begin
      row_dl_q[i] <= row_dl_q[i-1];
    end
  end

  // Lower lane holds the earlier entry, so it wins a tie.
  always_comb begin
    row_found = 1'b0;
    row_sad   = '0;
    row_lane  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (lanes_i[l].hit && (!row_found || lanes_i[l].sad < row_sad)) begin
        row_found = 1'b1;
        row_sad   = lanes_i[l].sad;
        row_lane  = LANE_W'(l);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_tag_q   <= '0;
      c_found_q <= 1'b0;
    end else begin
      c_tag_q   <= tag_dl_q[LANE_LAT-1];
      c_found_q <= row_found;
    end
  end

  always_ff @(posedge clk_i) begin
    c_sad_q <= row_sad;
    c_idx_q <= {row_dl_q[LANE_LAT-1], row_lane};
  end

  always_comb begin
    best_found_d = best_found_q;
    best_sad_d   = best_sad_q;
    best_idx_d   = best_idx_q;
    if (c_tag_q.go) begin
      if (c_tag_q.first) begin
        best_found_d = 1'b0;
        best_sad_d   = '0;
        best_idx_d   = '0;
      end
      if (c_found_q && (!best_found_d || c_sad_q < best_sad_d)) begin
        best_found_d = 1'b1;
        best_sad_d   = c_sad_q;
        best_idx_d   = c_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      best_sad_q   <= '0;
      best_idx_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      best_found_q <= best_found_d;
      best_sad_q   <= best_sad_d;
      best_idx_q   <= best_idx_d;
      done_q       <= c_tag_q.go && c_tag_q.last;
    end
  end

  assign done_o  = done_q;
  assign found_o = best_found_q;
  assign idx_o   = best_idx_q;
  assign sad_o   = best_sad_q;

endmodule

@@ design/rgdm_checker.sv @@
// Port-level checks of the descriptor matcher, bound to the top level.
`include "assert_macros.svh"

module rgdm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input rgdm_pkg::in_req_t req_i,
  input logic              result_valid_o,
  input rgdm_pkg::result_t result_o
);
  import rgdm_pkg::*;

  `RGDM_ASSERT(a_strobe_in_query, result_valid_o |-> busy, "result strobe outside a query")
  `RGDM_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe repeated")
  `RGDM_ASSERT(a_unmatched_zero, (result_valid_o && !result_o.matched) |-> (result_o.ref_index == 9'd0 && result_o.distance_sum == 13'd0), "unmatched result carries nonzero fields")
  `RGDM_ASSERT(a_query_busy, (start && !busy && req_i.operation == OP_QUERY) |=> busy, "query did not raise busy")
  `RGDM_ASSERT(a_other_idle, (start && !busy && req_i.operation != OP_QUERY) |=> (!busy && !result_valid_o), "non-query request started work")

endmodule

bind radius_gated_descriptor_match rgdm_checker u_rgdm_checker (.*);
